[rtl/tlg_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and types for the toroidal life grid block.
// No dependencies; imported by the cell memory and the top level.
package tlg_pkg;

    localparam int unsigned CELL_W = 2;
    localparam int unsigned DIM_W = 7;
    localparam int unsigned COORD_W = 6;
    localparam int unsigned DEF_MAX_WIDTH = 64;
    localparam int unsigned DEF_MAX_HEIGHT = 64;
    localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;
    localparam int unsigned IN_TDATA_W = 16;
    localparam int unsigned OUT_TDATA_W = 8;

    typedef enum logic [1:0] {
        REQ_LOAD    = 2'd0,
        REQ_STEP    = 2'd1,
        REQ_RESTORE = 2'd2,
        REQ_READ    = 2'd3
    } req_t;

    typedef enum logic [0:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } cfg_idx_t;

    // Cell bits: bit 0 alive, bit 1 obstacle.
    localparam int unsigned BIT_ALIVE = 0;
    localparam int unsigned BIT_OBST = 1;

    // Neighbour sweep: nine reads, index four is the cell itself.
    localparam logic [3:0] NB_CENTRE = 4'd4;
    localparam logic [3:0] NB_DONE = 4'd9;

endpackage

[rtl/tlg_ram.sv]
`timescale 1ns / 1ps
// Single-port-write, single-port-read cell memory with registered read data.
// Depends on tlg_pkg for the cell width.
module tlg_ram #(
    parameter int unsigned DEPTH = 4096,
    parameter int unsigned AW = 12
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [tlg_pkg::CELL_W-1:0] wdata,
    input  logic [AW-1:0]             raddr,
    output logic [tlg_pkg::CELL_W-1:0] rdata
);
    import tlg_pkg::*;

    logic [CELL_W-1:0] mem [DEPTH];
    logic [CELL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/toroidal_life_grid_with_obstacles_unit.sv]
`timescale 1ns / 1ps
// Toroidal life grid with obstacles. A step reads nine cells per cell through the single
// current-grid read port for the neighbour pass, then copies the new generation.
// One transaction is worked on at a time; a result waits in an output register.
// After reset a clearing pass zeroes the current and initial grids first.
// Depends on tlg_pkg and tlg_ram.
module toroidal_life_grid_with_obstacles_unit #(
    parameter int unsigned MAX_WIDTH = tlg_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = tlg_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // req_type[1:0], row[7:2], col[13:8], cell_code[15:14]
    input  logic [tlg_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // alive[0], obstacle[1], zeros above
    output logic [tlg_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                            cfg_we,
    input  logic [0:0]                      cfg_index,
    input  logic [tlg_pkg::DIM_W-1:0]       cfg_data
);
    import tlg_pkg::*;

    localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned MAXW_CL = (MAX_WIDTH > 127) ? 127 : MAX_WIDTH;
    localparam int unsigned MAXH_CL = (MAX_HEIGHT > 127) ? 127 : MAX_HEIGHT;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_RD    = 7'b0000100,
        S_NB    = 7'b0001000,
        S_COPY  = 7'b0010000,
        S_REST  = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [DIM_W-1:0] gw_reg, gw_next, gh_reg, gh_next;
    logic [DIM_W-1:0] r_reg, r_next, c_reg, c_next;
    logic [3:0] k_reg, k_next, cnt_reg, cnt_next;
    logic [CELL_W-1:0] ctr_reg, ctr_next, res_reg, res_next;
    logic [AW-1:0] lin_reg, lin_next, wa_reg, wa_next;
    logic wb_v_reg, wb_v_next, end_reg, end_next, rd_in_reg, rd_in_next;
    logic out_v_reg, out_v_next;
    logic [CELL_W-1:0] out_d_reg, out_d_next;

    logic [DIM_W-1:0] w_eff, h_eff;
    logic [1:0] in_req;
    logic [COORD_W-1:0] in_row, in_col;
    logic [CELL_W-1:0] in_code;
    logic in_range, accept;
    logic [DIM_W-1:0] nb_r, nb_c;
    logic [3:0] n_final;
    logic add_live, last_cell;
    logic [CELL_W-1:0] new_cell;

    logic cur_we, ini_we, nxt_we;
    logic [AW-1:0] cur_wa, cur_ra, ini_wa, nxt_a, in_addr, rc_addr;
    logic [CELL_W-1:0] cur_wd, ini_wd, cur_rd, ini_rd, nxt_rd;

    assign in_req = s_axis_tdata[1:0];
    assign in_row = s_axis_tdata[7:2];
    assign in_col = s_axis_tdata[13:8];
    assign in_code = s_axis_tdata[15:14];

    always_comb
    begin
        if (gw_reg == '0)
            w_eff = DIM_W'(1);
        else if (gw_reg > DIM_W'(MAXW_CL))
            w_eff = DIM_W'(MAXW_CL);
        else
            w_eff = gw_reg;
        if (gh_reg == '0)
            h_eff = DIM_W'(1);
        else if (gh_reg > DIM_W'(MAXH_CL))
            h_eff = DIM_W'(MAXH_CL);
        else
            h_eff = gh_reg;
    end

    assign in_range = ({1'b0, in_row} < h_eff) && ({1'b0, in_col} < w_eff);
    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept = s_axis_tvalid && s_axis_tready;
    assign in_addr = AW'(AW'(in_row) * AW'(MAX_WIDTH) + AW'(in_col));
    assign rc_addr = AW'(AW'(r_reg) * AW'(MAX_WIDTH) + AW'(c_reg));

    // Wrapped neighbour coordinates for sweep index k: rows by k/3, columns by k%3.
    always_comb
    begin
        case (k_reg)
            4'd0, 4'd1, 4'd2:
                nb_r = (r_reg == '0) ? h_eff - DIM_W'(1) : r_reg - DIM_W'(1);
            4'd6, 4'd7, 4'd8:
                nb_r = (r_reg == h_eff - DIM_W'(1)) ? '0 : r_reg + DIM_W'(1);
            default:
                nb_r = r_reg;
        endcase
        case (k_reg)
            4'd0, 4'd3, 4'd6:
                nb_c = (c_reg == '0) ? w_eff - DIM_W'(1) : c_reg - DIM_W'(1);
            4'd2, 4'd5, 4'd8:
                nb_c = (c_reg == w_eff - DIM_W'(1)) ? '0 : c_reg + DIM_W'(1);
            default:
                nb_c = c_reg;
        endcase
    end

    assign add_live = cur_rd[BIT_ALIVE] && !cur_rd[BIT_OBST];
    assign n_final = cnt_reg + {3'b0, add_live};
    assign last_cell = (r_reg == h_eff - DIM_W'(1)) && (c_reg == w_eff - DIM_W'(1));

    always_comb
    begin
        if (ctr_reg[BIT_OBST])
            new_cell = ctr_reg;
        else if (ctr_reg[BIT_ALIVE])
            new_cell = {1'b0, (n_final == 4'd2) || (n_final == 4'd3)};
        else
            new_cell = {1'b0, n_final == 4'd3};
    end

    always_comb
    begin
        state_next = state_reg;
        gw_next = gw_reg;
        gh_next = gh_reg;
        r_next = r_reg;
        c_next = c_reg;
        k_next = k_reg;
        cnt_next = cnt_reg;
        ctr_next = ctr_reg;
        res_next = res_reg;
        lin_next = lin_reg;
        wa_next = wa_reg;
        wb_v_next = 1'b0;
        end_next = end_reg;
        rd_in_next = rd_in_reg;
        out_v_next = out_v_reg;
        out_d_next = out_d_reg;

        cur_we = 1'b0;
        cur_wa = wa_reg;
        cur_wd = (state_reg == S_REST) ? ini_rd : nxt_rd;
        cur_ra = AW'(AW'(nb_r) * AW'(MAX_WIDTH) + AW'(nb_c));
        ini_we = 1'b0;
        ini_wa = in_addr;
        ini_wd = in_code;
        nxt_we = 1'b0;
        nxt_a = rc_addr;

        if (cfg_we)
        begin
            if (cfg_index == CFG_WIDTH)
                gw_next = cfg_data;
            else
                gh_next = cfg_data;
        end

        if (out_v_reg && m_axis_tready)
            out_v_next = 1'b0;

        // Write-back of a copy sweep lands in the cycle after its read.
        if (wb_v_reg)
            cur_we = 1'b1;

        case (state_reg)
            S_CLEAR:
            begin
                cur_we = 1'b1;
                cur_wa = lin_reg;
                cur_wd = '0;
                ini_we = 1'b1;
                ini_wa = lin_reg;
                ini_wd = '0;
                lin_next = lin_reg + AW'(1);
                if (lin_reg == LAST_ADDR)
                begin
                    lin_next = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cur_ra = in_addr;
                if (accept)
                begin
                    res_next = '0;
                    r_next = '0;
                    c_next = '0;
                    k_next = '0;
                    cnt_next = '0;
                    lin_next = '0;
                    end_next = 1'b0;
                    rd_in_next = in_range;
                    case (in_req)
                        REQ_LOAD:
                        begin
                            if (in_range)
                            begin
                                cur_we = 1'b1;
                                cur_wa = in_addr;
                                cur_wd = in_code;
                                ini_we = 1'b1;
                            end
                            state_next = S_DONE;
                        end
                        REQ_STEP:
                            state_next = S_NB;
                        REQ_RESTORE:
                            state_next = S_REST;
                        default:
                            state_next = S_RD;
                    endcase
                end
            end
            S_RD:
            begin
                res_next = rd_in_reg ? cur_rd : '0;
                state_next = S_DONE;
            end
            S_NB:
            begin
                if (k_reg != '0)
                begin
                    if (k_reg == NB_CENTRE + 4'd1)
                        ctr_next = cur_rd;
                    else
                        cnt_next = cnt_reg + {3'b0, add_live};
                end
                k_next = k_reg + 4'd1;
                if (k_reg == NB_DONE)
                begin
                    nxt_we = 1'b1;
                    k_next = '0;
                    cnt_next = '0;
                    if (last_cell)
                    begin
                        r_next = '0;
                        c_next = '0;
                        state_next = S_COPY;
                    end
                    else if (c_reg == w_eff - DIM_W'(1))
                    begin
                        c_next = '0;
                        r_next = r_reg + DIM_W'(1);
                    end
                    else
                    begin
                        c_next = c_reg + DIM_W'(1);
                    end
                end
            end
            S_COPY:
            begin
                if (end_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    wb_v_next = 1'b1;
                    wa_next = rc_addr;
                    if (last_cell)
                        end_next = 1'b1;
                    else if (c_reg == w_eff - DIM_W'(1))
                    begin
                        c_next = '0;
                        r_next = r_reg + DIM_W'(1);
                    end
                    else
                        c_next = c_reg + DIM_W'(1);
                end
            end
            S_REST:
            begin
                if (end_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    wb_v_next = 1'b1;
                    wa_next = lin_reg;
                    lin_next = lin_reg + AW'(1);
                    if (lin_reg == LAST_ADDR)
                        end_next = 1'b1;
                end
            end
            S_DONE:
            begin
                if (!out_v_reg || m_axis_tready)
                begin
                    out_v_next = 1'b1;
                    out_d_next = res_reg;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            gw_reg <= DIM_RESET;
            gh_reg <= DIM_RESET;
            r_reg <= '0;
            c_reg <= '0;
            k_reg <= '0;
            cnt_reg <= '0;
            lin_reg <= '0;
            wb_v_reg <= 1'b0;
            end_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            gw_reg <= gw_next;
            gh_reg <= gh_next;
            r_reg <= r_next;
            c_reg <= c_next;
            k_reg <= k_next;
            cnt_reg <= cnt_next;
            lin_reg <= lin_next;
            wb_v_reg <= wb_v_next;
            end_reg <= end_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ctr_reg <= ctr_next;
        res_reg <= res_next;
        wa_reg <= wa_next;
        rd_in_reg <= rd_in_next;
        out_d_reg <= out_d_next;
    end

    tlg_ram #(.DEPTH(DEPTH), .AW(AW)) u_cur (
        .clk   (clk),
        .we    (cur_we),
        .waddr (cur_wa),
        .wdata (cur_wd),
        .raddr (cur_ra),
        .rdata (cur_rd)
    );

    tlg_ram #(.DEPTH(DEPTH), .AW(AW)) u_ini (
        .clk   (clk),
        .we    (ini_we),
        .waddr (ini_wa),
        .wdata (ini_wd),
        .raddr (lin_reg),
        .rdata (ini_rd)
    );

    tlg_ram #(.DEPTH(DEPTH), .AW(AW)) u_nxt (
        .clk   (clk),
        .we    (nxt_we),
        .waddr (nxt_a),
        .wdata (new_cell),
        .raddr (nxt_a),
        .rdata (nxt_rd)
    );

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata = {{(OUT_TDATA_W - CELL_W){1'b0}}, out_d_reg};

`ifndef SYNTHESIS
    a_wb_in_copy: assert property (@(posedge clk) disable iff (!rst_n)
        wb_v_reg |-> (state_reg == S_COPY || state_reg == S_REST))
        else $error("copy write-back outside a copy sweep");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_NB) |-> (cnt_reg <= 4'd8 && k_reg <= NB_DONE))
        else $error("neighbour sweep out of bounds");

    a_done_output: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && (!out_v_reg || m_axis_tready)) |=> m_axis_tvalid)
        else $error("finished transaction produced no result");
`endif

endmodule
